[rtl/ulw_pkg.sv]
`timescale 1ns / 1ps
package ulw_pkg;

	localparam int RING_DEPTH_DEF = 128;

	// operation codes
	localparam logic [2:0] FUNC_APPEND      = 3'd0;
	localparam logic [2:0] FUNC_TERM        = 3'd1;
	localparam logic [2:0] FUNC_STABLE      = 3'd2;
	localparam logic [2:0] FUNC_STABLE_SNAP = 3'd3;
	localparam logic [2:0] FUNC_RESTORE     = 3'd4;
	localparam logic [2:0] FUNC_READ        = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_BOUNDS = 2'd1;
	localparam logic [1:0] ERR_FULL   = 2'd2;

	typedef struct packed {
		logic [63:0] range_end;
		logic [31:0] payload;
		logic [63:0] term;
		logic [63:0] index;
		logic [2:0]  func;
	} req_t;

	// packed so that found is bit 0
	typedef struct packed {
		logic [1:0]  error;
		logic        last_valid;
		logic [63:0] last_index;
		logic        first_valid;
		logic [63:0] first_index;
		logic [31:0] payload_out;
		logic [63:0] term_out;
		logic        found;
	} res_t;

	typedef struct packed {
		logic [63:0] term;
		logic [31:0] payload;
	} entry_t;

endpackage

[rtl/raft_unstable_log_window.sv]
`timescale 1ns / 1ps
// Unstable log window for a consensus log: a ring of RING_DEPTH entries (term and
// payload handle) covering log indices base .. base+count-1, plus an optional
// pending snapshot. Each input transfer carries one operation in s_axis_tuser
// (append, term lookup, stable-to, stable-snapshot-to, restore, read entry) and
// yields exactly one output transfer with the lookup result, the first/last index
// after the operation and an error code. One item is in flight at a time. An item
// passes through capture, 64-bit offset compute, decide/update and result form, and
// its result is loaded into the output register at result form. A term lookup or
// stable-to inside the window and a non-empty in-bounds read add a ring read step
// before result form, because the ring memory's read is registered ahead of the term
// compare and window update. Result form waits while the output register still
// holds a result that has not been taken. The next item is taken while the previous
// result still waits in the output register.
// The ring needs no clearing after reset: slots outside the window are never read.
module raft_unstable_log_window #(
	parameter int RING_DEPTH = ulw_pkg::RING_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// index[63:0], term[127:64], payload[159:128], range_end[223:160]
	input  logic [223:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found[0], term_out[64:1], payload_out[96:65], first_index[160:97],
	// first_valid[161], last_index[225:162], last_valid[226], error[228:227], zero pad
	output logic [231:0] m_axis_tdata
);
	import ulw_pkg::*;

	localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);

	req_t          req;
	res_t          res;
	logic          mem_wr;
	logic          mem_rd;
	logic [SW-1:0] mem_addr;
	entry_t        mem_wdata;
	entry_t        mem_rdata;

	assign req.func      = s_axis_tuser;
	assign req.index     = s_axis_tdata[63:0];
	assign req.term      = s_axis_tdata[127:64];
	assign req.payload   = s_axis_tdata[159:128];
	assign req.range_end = s_axis_tdata[223:160];

	ulw_ring #(
		.RING_DEPTH (RING_DEPTH),
		.SW         (SW)
	) u_ring (
		.clk     (clk),
		.wr_en   (mem_wr),
		.rd_en   (mem_rd),
		.addr    (mem_addr),
		.wr_data (mem_wdata),
		.rd_data (mem_rdata)
	);

	ulw_ctrl #(
		.RING_DEPTH (RING_DEPTH),
		.SW         (SW),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res),
		.mem_wr    (mem_wr),
		.mem_rd    (mem_rd),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	assign m_axis_tdata = {3'b000, res};

	// one item at a time: a transfer is never followed by another right away
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in flight");

	// the ring port never reads and writes in the same cycle
	a_ring_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr && mem_rd))
		else $error("ring read and write collide");

	// a pending snapshot always makes the last index meaningful
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[161] |-> m_axis_tdata[226])
		else $error("first index valid without last index");

	// only defined error codes leave the block
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[228:227] != 2'b11)
		else $error("undefined error code");

endmodule

[rtl/ulw_ring.sv]
`timescale 1ns / 1ps
module ulw_ring #(
	parameter int RING_DEPTH = ulw_pkg::RING_DEPTH_DEF,
	parameter int SW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [SW-1:0]     addr,
	input  ulw_pkg::entry_t   wr_data,
	output ulw_pkg::entry_t   rd_data
);
	import ulw_pkg::*;

	entry_t mem [RING_DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/ulw_ctrl.sv]
`timescale 1ns / 1ps
module ulw_ctrl #(
	parameter int RING_DEPTH = ulw_pkg::RING_DEPTH_DEF,
	parameter int SW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
	parameter int CW         = $clog2(RING_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ulw_pkg::req_t   req,
	output logic            res_valid,
	input  logic            res_ready,
	output ulw_pkg::res_t   res,
	output logic            mem_wr,
	output logic            mem_rd,
	output logic [SW-1:0]   mem_addr,
	output ulw_pkg::entry_t mem_wdata,
	input  ulw_pkg::entry_t mem_rdata
);
	import ulw_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CALC   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_READ   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

	// (head + offs) mod depth, correct for offs not above depth
	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
	                                          input logic [CW-1:0] offs);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(offs);
		if (sum >= (CW+1)'(RING_DEPTH)) begin
			sum = sum - (CW+1)'(RING_DEPTH);
		end
		return sum[SW-1:0];
	endfunction

	state_t state_q;

	// window state
	logic [63:0]   base_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] head_q;
	logic          snap_valid_q;
	logic [63:0]   snap_index_q;
	logic [63:0]   snap_term_q;

	// item registers
	req_t          req_s1;
	logic [63:0]   d_idx_s2;
	logic [63:0]   d_hi_s2;
	logic [63:0]   idx_inc_s2;
	logic          idx_ge_s2;
	logic          lo_gt_hi_s2;
	logic          lo_lt_hi_s2;
	logic          snap_eq_s2;
	logic [CW-1:0] drop_cnt_s3;
	logic [SW-1:0] drop_slot_s3;

	// partial result
	logic          found_q;
	logic [63:0]   term_res_q;
	logic [31:0]   pay_res_q;
	logic [1:0]    err_q;

	// output register
	logic          out_valid_q;
	res_t          out_q;

	// stage-one arithmetic
	logic [64:0] sub_idx;
	assign sub_idx = {1'b0, req_s1.index} - {1'b0, base_q};

	// decide-stage classification
	logic [CW-1:0] d_lo;
	logic          d_small;
	logic          eq_end;
	logic          in_win;
	logic          beyond;
	logic          at_or_below;
	logic          hi_over;
	logic          read_err;
	logic [CW-1:0] keep;
	logic [63:0]   new_base;
	logic          app_bound_err;
	logic          app_full;

	assign d_lo        = d_idx_s2[CW-1:0];
	assign d_small     = (d_idx_s2[63:CW] == '0);
	assign eq_end      = idx_ge_s2 && d_small && (d_lo == count_q);
	assign in_win      = idx_ge_s2 && d_small && (d_lo < count_q);
	assign beyond      = idx_ge_s2 && !(d_small && (d_lo <= count_q));
	assign at_or_below = !idx_ge_s2 || (d_idx_s2 == '0);
	assign hi_over     = !((d_hi_s2[63:CW] == '0) && (d_hi_s2[CW-1:0] <= count_q));
	assign read_err    = lo_gt_hi_s2 || !idx_ge_s2 || hi_over;

	always_comb begin
		keep          = count_q;
		new_base      = base_q;
		app_bound_err = 1'b0;
		if (eq_end) begin
			keep = count_q;
		end else if (at_or_below) begin
			keep     = '0;
			new_base = req_s1.index;
		end else if (beyond) begin
			app_bound_err = 1'b1;
		end else begin
			keep = d_lo;
		end
	end

	assign app_full = !app_bound_err && (keep == DEPTH_C);

	// ring port: write only on append, read only on lookups
	always_comb begin
		mem_wr    = 1'b0;
		mem_rd    = 1'b0;
		mem_addr  = slot_of(head_q, d_lo);
		mem_wdata = '{term: req_s1.term, payload: req_s1.payload};
		if (state_q == ST_DECIDE) begin
			case (req_s1.func)
				FUNC_APPEND: begin
					mem_addr = slot_of(head_q, keep);
					mem_wr   = !app_bound_err && !app_full;
				end
				FUNC_TERM: begin
					mem_rd = idx_ge_s2 && in_win;
				end
				FUNC_STABLE: begin
					mem_rd = in_win;
				end
				FUNC_READ: begin
					mem_rd = !read_err && lo_lt_hi_s2;
				end
				default: begin
					mem_rd = 1'b0;
				end
			endcase
		end
	end

	logic out_load;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || res_ready);
	assign req_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_q       <= '0;
			count_q      <= '0;
			head_q       <= '0;
			snap_valid_q <= 1'b0;
			snap_index_q <= '0;
			snap_term_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= mem_rd ? ST_READ : ST_DONE;
					case (req_s1.func)
						FUNC_APPEND: begin
							if (mem_wr) begin
								base_q  <= new_base;
								count_q <= keep + CW'(1);
							end
						end
						FUNC_STABLE_SNAP: begin
							if (snap_valid_q && snap_eq_s2) begin
								snap_valid_q <= 1'b0;
							end
						end
						FUNC_RESTORE: begin
							base_q       <= idx_inc_s2;
							count_q      <= '0;
							snap_valid_q <= 1'b1;
							snap_index_q <= req_s1.index;
							snap_term_q  <= req_s1.term;
						end
						default: begin
							base_q <= base_q;
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_DONE;
					if (req_s1.func == FUNC_STABLE && mem_rdata.term == req_s1.term) begin
						count_q <= count_q - drop_cnt_s3;
						head_q  <= drop_slot_s3;
						base_q  <= idx_inc_s2;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_s1 <= req;
		end
		if (state_q == ST_CALC) begin
			d_idx_s2    <= sub_idx[63:0];
			idx_ge_s2   <= !sub_idx[64];
			d_hi_s2     <= req_s1.range_end - base_q;
			idx_inc_s2  <= req_s1.index + 64'd1;
			lo_gt_hi_s2 <= req_s1.index > req_s1.range_end;
			lo_lt_hi_s2 <= req_s1.index < req_s1.range_end;
			snap_eq_s2  <= (snap_index_q == req_s1.index);
		end
		if (state_q == ST_DECIDE) begin
			drop_cnt_s3  <= d_lo + CW'(1);
			drop_slot_s3 <= slot_of(head_q, d_lo + CW'(1));
			found_q      <= 1'b0;
			term_res_q   <= '0;
			pay_res_q    <= '0;
			err_q        <= ERR_NONE;
			case (req_s1.func)
				FUNC_APPEND: begin
					if (app_bound_err) begin
						err_q <= ERR_BOUNDS;
					end else if (app_full) begin
						err_q <= ERR_FULL;
					end
				end
				FUNC_TERM: begin
					if (!idx_ge_s2 && snap_valid_q && snap_eq_s2) begin
						found_q    <= 1'b1;
						term_res_q <= snap_term_q;
					end
				end
				FUNC_READ: begin
					if (read_err) begin
						err_q <= ERR_BOUNDS;
					end
				end
				default: begin
					err_q <= ERR_NONE;
				end
			endcase
		end
		if (state_q == ST_READ) begin
			if (req_s1.func == FUNC_TERM) begin
				found_q    <= 1'b1;
				term_res_q <= mem_rdata.term;
			end else if (req_s1.func == FUNC_READ) begin
				found_q    <= 1'b1;
				term_res_q <= mem_rdata.term;
				pay_res_q  <= mem_rdata.payload;
			end
		end
		if (out_load) begin
			out_q.found       <= found_q;
			out_q.term_out    <= term_res_q;
			out_q.payload_out <= pay_res_q;
			out_q.error       <= err_q;
			out_q.first_valid <= snap_valid_q;
			out_q.first_index <= snap_valid_q ? snap_index_q + 64'd1 : '0;
			if (count_q != '0) begin
				out_q.last_index <= base_q + 64'(count_q) - 64'd1;
				out_q.last_valid <= 1'b1;
			end else begin
				out_q.last_index <= snap_valid_q ? snap_index_q : '0;
				out_q.last_valid <= snap_valid_q;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

[tb/sv/raft_unstable_log_window_tb.sv]
`timescale 1ns / 1ps
module raft_unstable_log_window_tb;
	import ulw_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;
	localparam logic [63:0] ALL1 = '1;

	localparam int RANDOM_GOAL = 1700;	// total transfers, directed part included
	localparam int CALM_ITEMS = 200;	// tail of the run with no idling at all
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_AT = 1000;
	localparam int FILL_RUN = 136;	// enough appends to hit ring full from empty
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	// one row of the directed table; typed rows carry status fields read off by hand
	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] index;
		logic [63:0] term;
		logic [31:0] payload;
		logic [63:0] range_end;
		logic        typed;
		logic [1:0]  err;
		logic [63:0] first_index;
		logic        first_valid;
		logic [63:0] last_index;
		logic        last_valid;
	} step_t;

	localparam step_t PLAN [0:26] = '{
		// after reset: nothing pending, empty range reads are fine, others out of bounds
		'{FUNC_TERM, 64'd0, 64'd0, 32'd0, 64'd0, 1'b1, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_READ, 64'd0, 64'd0, 32'd0, 64'd0, 1'b1, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_READ, 64'd0, 64'd0, 32'd0, 64'd1, 1'b1, ERR_BOUNDS, 64'd0, 1'b0, 64'd0, 1'b0},
		// append past the end of the window
		'{FUNC_APPEND, 64'd5, 64'd1, 32'd1, 64'd0, 1'b1, ERR_BOUNDS, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_APPEND, 64'd0, 64'd1, 32'hA, 64'd0, 1'b1, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b1},
		'{FUNC_APPEND, 64'd1, 64'd1, 32'hB, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_APPEND, 64'd2, 64'd2, 32'hC, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		// conflicting append cuts the window back
		'{FUNC_APPEND, 64'd1, 64'd3, 32'hD, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_TERM, 64'd1, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_READ, 64'd0, 64'd0, 32'd0, 64'd2, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		// reversed read range
		'{FUNC_READ, 64'd3, 64'd0, 32'd0, 64'd2, 1'b1, ERR_BOUNDS, 64'd0, 1'b0, 64'd1, 1'b1},
		// stable-to: wrong term, matching term, index outside
		'{FUNC_STABLE, 64'd0, 64'd9, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_STABLE, 64'd0, 64'd1, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_STABLE, 64'd5, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_RESTORE, 64'd10, 64'd7, 32'd0, 64'd0, 1'b1, ERR_NONE, 64'd11, 1'b1, 64'd10, 1'b1},
		'{FUNC_TERM, 64'd10, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_APPEND, 64'd11, 64'd8, 32'hE, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_STABLE_SNAP, 64'd9, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_STABLE_SNAP, 64'd10, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		// snapshot at the top index: base and first index wrap to zero
		'{FUNC_RESTORE, ALL1, ALL1, 32'd0, 64'd0, 1'b1, ERR_NONE, 64'd0, 1'b1, ALL1, 1'b1},
		'{FUNC_TERM, ALL1, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_APPEND, 64'd0, ALL1, 32'hFFFF_FFFF, ALL1, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_READ, 64'd0, 64'd0, 32'd0, 64'd1, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_READ, 64'd0, 64'd0, 32'd0, ALL1, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_SPARE6, ALL1, ALL1, 32'hFFFF_FFFF, ALL1, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		'{FUNC_SPARE7, 64'd0, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0},
		// append at the base clears the window
		'{FUNC_APPEND, 64'd0, 64'd0, 32'd0, 64'd0, 1'b0, ERR_NONE, 64'd0, 1'b0, 64'd0, 1'b0}
	};

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;	// index, term, payload, range_end
	logic [2:0]   s_axis_tuser;	// func
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [231:0] m_axis_tdata;	// found, term_out, payload_out, first_index, first_valid,
					// last_index, last_valid, error, zero pad

	raft_unstable_log_window DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// shadow of the log window
	logic [63:0]       win_base;
	int unsigned       win_count;
	logic [SLOT_W-1:0] win_head;
	logic [63:0]       slot_term [DEPTH];
	logic [31:0]       slot_pay [DEPTH];
	bit                snap_on;
	logic [63:0]       snap_at;
	logic [63:0]       snap_tm;

	res_t due_results [$];
	int   n_sent, n_results, n_fails, cycle_no;
	int   n_hits, n_bounds, n_full;
	bit   calm, quiet_burst, hold_req, held, drained;
	logic [63:0] run_term;
	res_t got_res, want_res;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SLOT_W-1:0] slot_at(input logic [63:0] offs);
		return win_head + offs[SLOT_W-1:0];
	endfunction

	// term at a log index: pending snapshot below the window, else a window entry
	function automatic bit term_of(input logic [63:0] i, output logic [63:0] t);
		t = '0;
		if (i < win_base) begin
			if (snap_on && snap_at == i) begin
				t = snap_tm;
				return 1'b1;
			end
			return 1'b0;
		end
		if (i - win_base < 64'(win_count)) begin
			t = slot_term[slot_at(i - win_base)];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// apply one operation to the shadow window and form its result
	task automatic window_step(input req_t op, output res_t r);
		logic [63:0]       new_base, keep, t, drop;
		logic [SLOT_W-1:0] s;
		bit                ok;
		r = '0;
		case (op.func)
		FUNC_APPEND: begin
			new_base = win_base;
			keep = 64'(win_count);
			ok = 1'b1;
			if (!(op.index >= win_base && op.index - win_base == 64'(win_count))) begin
				if (op.index <= win_base) begin
					new_base = op.index;
					keep = '0;
				end else if (op.index - win_base > 64'(win_count)) begin
					r.error = ERR_BOUNDS;
					ok = 1'b0;
				end else begin
					keep = op.index - win_base;
				end
			end
			// full check happens before any truncation takes effect
			if (ok && keep >= 64'(DEPTH)) begin
				r.error = ERR_FULL;
				ok = 1'b0;
			end
			if (ok) begin
				win_base = new_base;
				s = slot_at(keep);
				slot_term[s] = op.term;
				slot_pay[s] = op.payload;
				win_count = int'(keep) + 1;
			end
		end
		FUNC_TERM: begin
			if (term_of(op.index, t)) begin
				r.found = 1'b1;
				r.term_out = t;
			end
		end
		FUNC_STABLE: begin
			if (term_of(op.index, t) && t == op.term && op.index >= win_base) begin
				drop = op.index - win_base + 1;
				win_count = win_count - int'(drop);
				win_head = slot_at(drop);
				win_base = op.index + 1;
			end
		end
		FUNC_STABLE_SNAP: begin
			if (snap_on && snap_at == op.index)
				snap_on = 1'b0;
		end
		FUNC_RESTORE: begin
			win_base = op.index + 1;
			win_count = 0;
			snap_on = 1'b1;
			snap_at = op.index;
			snap_tm = op.term;
		end
		FUNC_READ: begin
			if (op.index > op.range_end || op.index < win_base ||
				op.range_end - win_base > 64'(win_count)) begin
				r.error = ERR_BOUNDS;
			end else if (op.index < op.range_end) begin
				s = slot_at(op.index - win_base);
				r.found = 1'b1;
				r.term_out = slot_term[s];
				r.payload_out = slot_pay[s];
			end
		end
		default: begin
		end
		endcase
		r.first_valid = snap_on;
		r.first_index = snap_on ? snap_at + 1 : '0;
		if (win_count > 0) begin
			r.last_index = win_base + 64'(win_count) - 1;
			r.last_valid = 1'b1;
		end else if (snap_on) begin
			r.last_index = snap_at;
			r.last_valid = 1'b1;
		end
	endtask

	// Offer one operation, starting just after a falling edge. Returns just after the
	// falling edge that follows its transfer, with tvalid still high.
	task automatic offer(input req_t op, input bit typed, input res_t want);
		res_t r;
		if (!calm && !quiet_burst && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {op.range_end, op.payload, op.term, op.index};
		s_axis_tuser <= op.func;
		do @(posedge clk); while (!s_axis_tready);
		window_step(op, r);
		due_results.push_back(typed ? want : r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic issue(input logic [2:0] f, input logic [63:0] idx, input logic [63:0] trm,
		input logic [31:0] pay, input logic [63:0] hi);
		req_t op;
		op.func = f;
		op.index = idx;
		op.term = trm;
		op.payload = pay;
		op.range_end = hi;
		offer(op, 1'b0, '0);
	endtask

	// Mostly well-formed traffic around the current window: runs of appends, stable
	// points taken from the window itself, reads and lookups at its edges, with
	// snapshot restores (some near the top of the index space) and raw noise mixed in.
	task automatic random_traffic(input int goal);
		logic [63:0] idx, trm, hi, t;
		int          kind, len;
		while (n_sent < goal) begin
			calm = (n_sent >= goal - CALM_ITEMS);
			quiet_burst = ($urandom_range(0, 3) == 0);
			if (!held && n_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!drained && n_sent >= DRAIN_AT) begin
				// sender pause until every result is back
				drained = 1'b1;
				s_axis_tvalid <= 1'b0;
				do @(negedge clk); while (due_results.size() != 0);
			end
			kind = $urandom_range(0, 19);
			if (kind <= 6) begin
				len = ($urandom_range(0, 39) == 0) ? FILL_RUN : $urandom_range(1, 10);
				case ($urandom_range(0, 5))
				0: idx = win_base + $urandom_range(0, win_count);
				1: idx = win_base - $urandom_range(0, 3);
				default: idx = win_base + 64'(win_count);
				endcase
				repeat (len) begin
					if ($urandom_range(0, 3) == 0)
						run_term += $urandom_range(1, 3);
					trm = ($urandom_range(0, 15) == 0) ? rand64() : run_term;
					issue(FUNC_APPEND, idx, trm, $urandom, rand64());
					idx = win_base + 64'(win_count);
				end
			end else if (kind <= 9) begin
				if (win_count > 0 && $urandom_range(0, 4) != 0)
					idx = win_base + $urandom_range(0, win_count - 1);
				else if (snap_on && $urandom_range(0, 1) == 0)
					idx = snap_at;
				else
					idx = win_base - 2 + $urandom_range(0, win_count + 4);
				if (!term_of(idx, t))
					t = run_term;
				trm = ($urandom_range(0, 3) == 0) ? t + 1 : t;
				issue(FUNC_STABLE, idx, trm, $urandom, rand64());
			end else if (kind <= 12) begin
				repeat ($urandom_range(1, 4)) begin
					idx = win_base + $urandom_range(0, win_count + 1) - $urandom_range(0, 1);
					hi = ($urandom_range(0, 7) == 0) ? idx - 1 : idx + $urandom_range(0, 3);
					issue(FUNC_READ, idx, rand64(), $urandom, hi);
				end
			end else if (kind <= 14) begin
				if (snap_on && $urandom_range(0, 3) == 0)
					idx = snap_at;
				else
					idx = win_base - 2 + $urandom_range(0, win_count + 3);
				issue(FUNC_TERM, idx, rand64(), $urandom, rand64());
			end else if (kind == 15) begin
				case ($urandom_range(0, 2))
				0: idx = rand64();
				1: idx = ALL1 - $urandom_range(0, 6);
				default: idx = win_base + $urandom_range(0, 40);
				endcase
				trm = ($urandom_range(0, 1) == 0) ? rand64() : run_term;
				issue(FUNC_RESTORE, idx, trm, $urandom, rand64());
			end else if (kind == 16) begin
				idx = ($urandom_range(0, 1) == 0) ? snap_at : snap_at + $urandom_range(0, 2) - 1;
				issue(FUNC_STABLE_SNAP, idx, rand64(), $urandom, rand64());
			end else if (kind <= 18) begin
				issue(3'($urandom_range(0, 7)), rand64(), rand64(), $urandom, rand64());
			end else begin
				issue(($urandom_range(0, 1) == 0) ? FUNC_SPARE6 : FUNC_SPARE7,
					rand64(), rand64(), $urandom, rand64());
			end
		end
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] got_v,
		input logic [63:0] want_v);
		n_fails++;
		$display("MISMATCH result %0d %s: got %h expected %h", n_results, what, got_v, want_v);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("Timeout at cycle %0d: %0d sent, %0d results outstanding",
				cycle_no, n_sent, due_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result checker: sampled at the rising edge, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			got_res = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
			if (due_results.size() == 0) begin
				note_mismatch("unexpected transfer", got_res.last_index, '0);
			end else begin
				want_res = due_results.pop_front();
				if (want_res.found)
					n_hits++;
				if (want_res.error == ERR_BOUNDS)
					n_bounds++;
				if (want_res.error == ERR_FULL)
					n_full++;
				if (got_res.found !== want_res.found)
					note_mismatch("found", 64'(got_res.found), 64'(want_res.found));
				if (got_res.term_out !== want_res.term_out)
					note_mismatch("term_out", got_res.term_out, want_res.term_out);
				if (got_res.payload_out !== want_res.payload_out)
					note_mismatch("payload_out", 64'(got_res.payload_out), 64'(want_res.payload_out));
				if (got_res.first_index !== want_res.first_index)
					note_mismatch("first_index", got_res.first_index, want_res.first_index);
				if (got_res.first_valid !== want_res.first_valid)
					note_mismatch("first_valid", 64'(got_res.first_valid), 64'(want_res.first_valid));
				if (got_res.last_index !== want_res.last_index)
					note_mismatch("last_index", got_res.last_index, want_res.last_index);
				if (got_res.last_valid !== want_res.last_valid)
					note_mismatch("last_valid", 64'(got_res.last_valid), 64'(want_res.last_valid));
				if (got_res.error !== want_res.error)
					note_mismatch("error", 64'(got_res.error), 64'(want_res.error));
			end
		end
	end

	// output side: random stall bursts, one long hold-off on request, none at the end
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		req_t op;
		res_t want;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		win_base = '0;
		win_count = 0;
		win_head = '0;
		snap_on = 1'b0;
		snap_at = '0;
		snap_tm = '0;
		run_term = 64'd1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			op.func = PLAN[i].func;
			op.index = PLAN[i].index;
			op.term = PLAN[i].term;
			op.payload = PLAN[i].payload;
			op.range_end = PLAN[i].range_end;
			want = '0;
			want.error = PLAN[i].err;
			want.first_index = PLAN[i].first_index;
			want.first_valid = PLAN[i].first_valid;
			want.last_index = PLAN[i].last_index;
			want.last_valid = PLAN[i].last_valid;
			offer(op, PLAN[i].typed, want);
		end

		random_traffic(RANDOM_GOAL);
		s_axis_tvalid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d operations (directed table, then window-tracking random traffic)",
			n_sent);
		$display("%0d results: %0d hits, %0d out-of-bounds, %0d ring-full;",
			n_results, n_hits, n_bounds, n_full);
		$display("long hold-off and drain done");
		if (n_fails == 0 && due_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
